// File: hdl/pu2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pu2a_pkg
// widths, register indexes and channel averaging for the 2x upscaler
// ----------------------------------------------------------------------------
package pu2a_pkg;

  localparam int PIX_W  = 32;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 12;
  localparam int CFG_W  = 12;
  localparam int IDX_W  = 1;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [COL_W-1:0] WIDTH_RESET  = 10'd256;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 12'd240;

  localparam logic [PIX_W-1:0] HALF_MASK = 32'h7F7F7F7F;

  // tdata of the result: four pixels, column, row, zero fill to whole bytes
  localparam int OUT_BITS   = 4 * PIX_W + COL_W + ROW_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // per-channel average, each channel halved first so nothing carries
  function automatic logic [PIX_W-1:0] avg_channels(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b);
    avg_channels = ((a >> 1) & HALF_MASK) + ((b >> 1) & HALF_MASK);
  endfunction

endpackage
`default_nettype wire

// File: hdl/pixel_upscale_2x_average_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_upscale_2x_average_top
// 2x upscaler: past the first row and column, emits a 2x2 block, three of its pixels averaged, per source pixel
// ----------------------------------------------------------------------------
// Takes one source pixel per clock in raster order over a frame of
// (image_height+1) rows of (image_width+1) pixels and returns one 2x2 output
// word for each pixel past the first row and column. Each taken pixel goes
// through the row memory read in stage one, then the averaging into the
// output register. The previous row lives in a single-port row memory read and
// written at the same column in the cycle a pixel is taken, so the throughput
// is one pixel per clock whenever the output side keeps up. Configuration must
// be written only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module pixel_upscale_2x_average_top
  import pu2a_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [PIX_W-1:0]      s_tdata,   // pixel_word
  input  wire logic                  s_tuser,   // frame_start
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  // top_left, top_right, bottom_left, bottom_right, source_column,
  // source_row, zero fill
  output      logic [OUT_DATA_W-1:0] m_tdata,
  output      logic                  m_tlast    // frame_end
);

  localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam logic [AW-1:0] SLOT_LAST = AW'(MAX_ROW_PIXELS - 1);

  logic [COL_W-1:0] image_width;
  logic [ROW_W-1:0] image_height;

  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [AW-1:0]    slot, slot_next;

  logic [COL_W-1:0] col_eff;
  logic [ROW_W-1:0] row_eff;
  logic [AW-1:0]    slot_eff;

  logic [PIX_W-1:0] row_mem [MAX_ROW_PIXELS];
  logic [PIX_W-1:0] above;

  logic             s1_valid;
  logic             s1_emit;
  logic             s1_fend;
  logic [PIX_W-1:0] s1_pix;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;

  logic [PIX_W-1:0] above_left_pixel;
  logic [PIX_W-1:0] current_left_pixel;

  logic             s_acc;
  logic             out_free;
  logic             move1;

  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign move1    = s1_valid && (!s1_emit || out_free);
  assign s_tready = !s1_valid || move1;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[COL_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // position counters
  always_comb begin
    col_eff  = s_tuser ? '0 : column_count;
    row_eff  = s_tuser ? '0 : row_count;
    slot_eff = s_tuser ? '0 : slot;
    if (col_eff >= image_width) begin
      column_count_next = '0;
      slot_next         = '0;
      row_count_next    = (row_eff >= image_height) ? '0 : row_eff + 1'b1;
    end else begin
      column_count_next = col_eff + 1'b1;
      slot_next         = (slot_eff == SLOT_LAST) ? '0 : slot_eff + 1'b1;
      row_count_next    = row_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      slot         <= '0;
    end else if (s_acc) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      slot         <= slot_next;
    end
  end

  // row memory, read old data and write new pixel at the same column
  always_ff @(posedge clk) begin
    if (s_acc) begin
      row_mem[slot_eff] <= s_tdata;
      above             <= row_mem[slot_eff];
    end
  end

  // stage one: fields alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_acc) begin
      s1_valid <= 1'b1;
    end else if (move1) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_pix  <= s_tdata;
      s1_emit <= (col_eff != '0) && (row_eff != '0);
      s1_fend <= (col_eff == image_width) && (row_eff == image_height);
      s1_col  <= col_eff - 1'b1;
      s1_row  <= row_eff - 1'b1;
    end
  end

  // neighbor pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      above_left_pixel   <= '0;
      current_left_pixel <= '0;
    end else if (move1) begin
      above_left_pixel   <= above;
      current_left_pixel <= s1_pix;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move1 && s1_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move1 && s1_emit) begin
      m_tdata <= OUT_DATA_W'({s1_row, s1_col,
                              avg_channels(above, current_left_pixel),
                              avg_channels(above_left_pixel, current_left_pixel),
                              avg_channels(above_left_pixel, above),
                              above_left_pixel});
      m_tlast <= s1_fend;
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_pixel_upscale_2x_average_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_upscale_2x_average_top
// self-checking bench for the 2x averaging upscaler
// ----------------------------------------------------------------------------
// Streams source frames into the block under random idle on both sides and
// predicts every 2x2 output word from a line-buffer model kept in the bench.
// Directed tests cover reset sizes, channel extremes, register masking, a
// wide row, a tall frame, frame wrap and restart, and a long output hold; a
// random phase runs small frames over changing sizes. Output words are
// checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_pixel_upscale_2x_average_top;
  import pu2a_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] top_left;
    logic [PIX_W-1:0] top_right;
    logic [PIX_W-1:0] bottom_left;
    logic [PIX_W-1:0] bottom_right;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             frame_end;
  } block_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  // line buffer model
  logic [PIX_W-1:0] line_mem [1024];
  logic [PIX_W-1:0] above_prev;
  logic [PIX_W-1:0] left_pix;
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] cur_width;
  logic [ROW_W-1:0] cur_height;

  block_t pending_blocks [$];
  int     mismatch_count = 0;
  int     pixels_sent = 0;
  int     hold_request = 0;
  bit     sender_steady = 0;
  bit     receiver_steady = 0;

  pixel_upscale_2x_average_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [PIX_W-1:0] halve_sum(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    for (int ch = 0; ch < 4; ch++)
      r[8*ch +: 8] = {1'b0, a[8*ch+1 +: 7]} + {1'b0, b[8*ch+1 +: 7]};
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int frame_size();
    return (int'(cur_width) + 1) * (int'(cur_height) + 1);
  endfunction

  task automatic predict_block(input logic [PIX_W-1:0] pix, input logic fs);
    logic [PIX_W-1:0] above;
    block_t b;
    if (fs) begin
      col_pos = '0;
      row_pos = '0;
    end
    above = line_mem[col_pos];
    if (col_pos >= 1 && row_pos >= 1) begin
      b.top_left     = above_prev;
      b.top_right    = halve_sum(above_prev, above);
      b.bottom_left  = halve_sum(above_prev, left_pix);
      b.bottom_right = halve_sum(above, left_pix);
      b.column       = col_pos - 1'b1;
      b.row          = row_pos - 1'b1;
      b.frame_end    = (col_pos == cur_width) && (row_pos == cur_height);
      pending_blocks.push_back(b);
    end
    line_mem[col_pos] = pix;
    above_prev = above;
    left_pix = pix;
    if (col_pos >= cur_width) begin
      col_pos = '0;
      if (row_pos >= cur_height) row_pos = '0;
      else row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= fs;
    do @(posedge clk); while (!s_tready);
    predict_block(pix, fs);
    pixels_sent++;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic fs_first, input int count);
    for (int i = 0; i < count; i++)
      send_pixel($urandom, (i == 0) ? fs_first : 1'b0);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
  endtask

  // pipeline holds words that produce no output, so keep clocking after the drain
  task automatic settle();
    drain();
    repeat (6) @(posedge clk);
  endtask

  task automatic set_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) cur_width = val[COL_W-1:0];
    else cur_height = val[ROW_W-1:0];
  endtask

  task automatic configure(input int w, input int h);
    settle();
    if ($urandom_range(0, 1)) begin
      set_register(REG_IMAGE_WIDTH, CFG_W'(w));
      set_register(REG_IMAGE_HEIGHT, CFG_W'(h));
    end else begin
      set_register(REG_IMAGE_HEIGHT, CFG_W'(h));
      set_register(REG_IMAGE_WIDTH, CFG_W'(w));
    end
  endtask

  task automatic test_reset_sizes();
    // no frame start: counters must already be cleared by reset
    send_frame(1'b0, int'(WIDTH_RESET) + 9);
  endtask

  task automatic test_channel_extremes();
    logic [PIX_W-1:0] pattern [12];
    pattern = '{32'h00000000, 32'hFFFFFFFF, 32'h01010101, 32'hFEFEFEFE,
                32'h80808080, 32'h7F7F7F7F, 32'hFFFFFFFF, 32'h00000000,
                32'hFF00FF00, 32'h00FF00FF, 32'h81818181, 32'hA5A55A5A};
    configure(3, 2);
    for (int i = 0; i < 12; i++) send_pixel(pattern[i], i == 0);
  endtask

  task automatic test_register_masking();
    settle();
    // upper data bits fall outside the width register
    set_register(REG_IMAGE_WIDTH, 12'hC02);
    set_register(REG_IMAGE_HEIGHT, 12'd1);
    send_frame(1'b1, frame_size());
  endtask

  task automatic test_wide_row();
    configure(160, 1);
    send_frame(1'b1, frame_size());
  endtask

  task automatic test_tall_frame();
    configure(1, 100);
    send_frame(1'b1, frame_size());
  endtask

  task automatic test_frame_wrap();
    configure(4, 3);
    send_frame(1'b1, frame_size());
    send_frame(1'b0, frame_size());
    send_frame(1'b0, frame_size());
    send_frame(1'b0, 7);
    send_frame(1'b1, frame_size());
    send_frame(1'b0, 13);
    send_frame(1'b1, frame_size());
  endtask

  task automatic test_backpressure();
    configure(7, 5);
    sender_steady = 1'b1;
    hold_request = 120;
    send_frame(1'b1, 3 * frame_size());
    sender_steady = 1'b0;
    drain();
    send_frame(1'b0, frame_size());
    send_frame(1'b0, frame_size());
  endtask

  task automatic test_random_frames();
    int  target;
    int  w;
    int  h;
    int  frames;
    bit  need_start;
    target = pixels_sent + 150;
    while (pixels_sent < target) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 80) : $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      configure(w, h);
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = sender_steady;
      need_start = 1'b1;
      frames = $urandom_range(2, 5);
      for (int f = 0; f < frames && pixels_sent < target; f++) begin
        if ($urandom_range(0, 5) == 0) begin
          send_frame(1'b1, $urandom_range(1, frame_size() - 1));
          need_start = 1'b1;
        end else begin
          send_frame(need_start ? 1'b1 : 1'($urandom_range(0, 1)), frame_size());
          need_start = 1'b0;
        end
      end
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    for (int i = 0; i < 1024; i++) line_mem[i] = '0;
    above_prev = '0;
    left_pix   = '0;
    col_pos    = '0;
    row_pos    = '0;
    cur_width  = WIDTH_RESET;
    cur_height = HEIGHT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_sizes();
    test_channel_extremes();
    test_register_masking();
    test_wide_row();
    test_tall_frame();
    test_frame_wrap();
    test_backpressure();
    test_random_frames();
    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_blocks.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver: random stalls, steady stretches, one long hold on request
  initial begin
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (stall == 0 && !receiver_steady) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    block_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_blocks.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = pending_blocks.pop_front();
          compare_field("top_left", want.top_left, m_tdata[0 +: PIX_W]);
          compare_field("top_right", want.top_right, m_tdata[PIX_W +: PIX_W]);
          compare_field("bottom_left", want.bottom_left, m_tdata[2*PIX_W +: PIX_W]);
          compare_field("bottom_right", want.bottom_right, m_tdata[3*PIX_W +: PIX_W]);
          compare_field("source_column", 32'(want.column), 32'(m_tdata[4*PIX_W +: COL_W]));
          compare_field("source_row", 32'(want.row),
                        32'(m_tdata[4*PIX_W+COL_W +: ROW_W]));
          compare_field("frame_end", 32'(want.frame_end), 32'(m_tlast));
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
